/* rtl/ci2f_pkg.sv */
// ----------------------------------------------------------------------------
// ci2f_pkg
// Shared types and constants of the complex int16 to float32 scaler.
// ----------------------------------------------------------------------------
package ci2f_pkg;

	// wire format codes (code three reads as chdr)
	localparam logic [1:0] FMT_ITEM32_LE = 2'd0;
	localparam logic [1:0] FMT_ITEM32_BE = 2'd1;
	localparam logic [1:0] FMT_CHDR      = 2'd2;

	// register indexes
	localparam logic REG_WIRE_FORMAT = 1'b0;
	localparam logic REG_SCALE_BITS  = 1'b1;

	localparam int          PADDR_W     = 3;
	localparam logic [31:0] ONE_F32     = 32'h3F80_0000;
	localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
	localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
	localparam logic [30:0] INF_MAG     = 31'h7F80_0000;

	// configuration as seen by the datapath
	typedef struct packed {
		logic [1:0]  wire_format;
		logic [31:0] scale_bits;
	} cfg_t;

endpackage

/* rtl/ci2f_if.sv */
// ----------------------------------------------------------------------------
// ci2f_in_if / ci2f_out_if
// Valid/ready channels for sample words and converted samples.
// ----------------------------------------------------------------------------
interface ci2f_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] raw_word;
	logic        last_in;
	modport source (output valid, raw_word, last_in, input ready);
	modport sink   (input valid, raw_word, last_in, output ready);
endinterface

interface ci2f_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] real_out;
	logic [31:0] imag_out;
	logic        last_out;
	modport source (output valid, real_out, imag_out, last_out, input ready);
	modport sink   (input valid, real_out, imag_out, last_out, output ready);
endinterface

/* rtl/ci2f_regs.sv */
// ----------------------------------------------------------------------------
// ci2f_regs
// APB register file holding wire format and scale factor.
// ----------------------------------------------------------------------------
module ci2f_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ci2f_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output ci2f_pkg::cfg_t               cfg
);
	import ci2f_pkg::*;

	logic [1:0]  wire_format_q;
	logic [31:0] scale_bits_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wire_format_q <= FMT_ITEM32_LE;
			scale_bits_q  <= ONE_F32;
		end else if (wr_en) begin
			case (paddr[2])
				REG_WIRE_FORMAT: wire_format_q <= pwdata[1:0];
				REG_SCALE_BITS:  scale_bits_q  <= pwdata;
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (paddr[2])
			REG_WIRE_FORMAT: prdata = {30'd0, wire_format_q};
			REG_SCALE_BITS:  prdata = scale_bits_q;
			default:         prdata = 32'd0;
		endcase
	end

	assign cfg.wire_format = wire_format_q;
	assign cfg.scale_bits  = scale_bits_q;
endmodule

/* rtl/ci2f_part.sv */
// ----------------------------------------------------------------------------
// ci2f_part
// Three-stage multiply, normalize and round of one int16 part by a float32.
// ----------------------------------------------------------------------------
module ci2f_part (
	input  logic        clk,
	input  logic        adv,
	input  logic [15:0] part,
	input  logic [31:0] scale,
	output logic [31:0] result
);
	import ci2f_pkg::*;

	// stage one: magnitude, special cases, integer multiply
	logic        neg;
	logic [15:0] mag;
	logic [7:0]  ex;
	logic [22:0] fr;
	logic        sgn;
	logic        spec;
	logic [31:0] spec_val;
	logic [7:0]  eeff;
	logic [23:0] sig;

	always_comb begin
		neg  = part[15];
		mag  = neg ? (~part + 16'd1) : part;
		ex   = scale[30:23];
		fr   = scale[22:0];
		sgn  = scale[31] ^ neg;
		eeff = (ex == 8'd0) ? 8'd1 : ex;
		sig  = {(ex != 8'd0), fr};
		spec     = 1'b1;
		spec_val = {sgn, INF_MAG};
		if (ex == 8'hFF) begin
			if (fr != 23'd0)        spec_val = scale | QUIET_BIT;
			else if (mag == 16'd0)  spec_val = DEFAULT_NAN;
		end else if (mag == 16'd0) begin
			spec_val = {scale[31], 31'd0};
		end else if (ex == 8'd0 && fr == 23'd0) begin
			spec_val = {sgn, 31'd0};
		end else begin
			spec = 1'b0;
		end
	end

	logic [39:0] prod_s2;
	logic [7:0]  eeff_s2;
	logic        sgn_s2;
	logic        spec_s2;
	logic [31:0] spec_val_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2     <= 40'(mag) * 40'(sig);
			eeff_s2     <= eeff;
			sgn_s2      <= sgn;
			spec_s2     <= spec;
			spec_val_s2 <= spec_val;
		end
	end

	// stage two: leading zero count and normalizing shift
	logic [5:0]         lz;
	logic [39:0]        norm;
	logic signed [10:0] be;
	logic [39:0]        sub_shift;

	always_comb begin
		lz = 6'd39;
		for (int i = 0; i < 40; i++) begin
			if (prod_s2[i]) lz = 6'(39 - i);
		end
		norm      = prod_s2 << lz;
		be        = 11'sd16 + $signed({3'd0, eeff_s2}) - $signed({5'd0, lz});
		sub_shift = prod_s2 << (eeff_s2 - 8'd1);
	end

	logic [24:0]        norm_s3;
	logic               sticky_s3;
	logic signed [10:0] be_s3;
	logic [22:0]        sub_s3;
	logic               sgn_s3;
	logic               spec_s3;
	logic [31:0]        spec_val_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			norm_s3     <= norm[39:15];
			sticky_s3   <= |norm[14:0];
			be_s3       <= be;
			sub_s3      <= sub_shift[22:0];
			sgn_s3      <= sgn_s2;
			spec_s3     <= spec_s2;
			spec_val_s3 <= spec_val_s2;
		end
	end

	// stage three: round to nearest even, pack
	logic [24:0]        sum;
	logic               rnd;
	logic signed [10:0] be_r;
	logic [22:0]        frac;
	logic [31:0]        packed_val;

	always_comb begin
		rnd  = norm_s3[0] && (sticky_s3 || norm_s3[1]);
		sum  = {1'b0, norm_s3[24:1]} + {24'd0, rnd};
		frac = sum[24] ? sum[23:1] : sum[22:0];
		be_r = be_s3 + $signed({10'd0, sum[24]});
		if (spec_s3)                 packed_val = spec_val_s3;
		else if (be_s3 < 11'sd1)     packed_val = {sgn_s3, 8'd0, sub_s3};
		else if (be_r >= 11'sd255)   packed_val = {sgn_s3, INF_MAG};
		else                         packed_val = {sgn_s3, be_r[7:0], frac};
	end

	always_ff @(posedge clk) begin
		if (adv) result <= packed_val;
	end
endmodule

/* rtl/complex_int16_to_float32_scaler_core.sv */
// ----------------------------------------------------------------------------
// complex_int16_to_float32_scaler_core
// Converts complex int16 sample words to scaled float32 pairs.
// ----------------------------------------------------------------------------
// One sample word is taken per clock and its two float32 parts pass through the
// input register, multiply, normalize and round/output register stages.
// Throughput is one sample per clock; when the output is stalled the whole
// pipeline holds and din.ready drops. Registers: wire_format at 0x0, scale_bits
// at 0x4; change them only while the pipeline is empty.
module complex_int16_to_float32_scaler_core (
	input  logic                         clk,
	input  logic                         arst_n,
	ci2f_in_if.sink                      din,
	ci2f_out_if.source                   dout,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ci2f_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import ci2f_pkg::*;

	cfg_t cfg;

	ci2f_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// pipeline advance: whole pipe moves unless the output is stalled
	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic last_s1, last_s2, last_s3, last_s4;
	logic [31:0] raw_s1;

	assign adv       = !vld_s4 || dout.ready;
	assign din.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= din.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			raw_s1  <= din.raw_word;
			last_s1 <= din.last_in;
			last_s2 <= last_s1;
			last_s3 <= last_s2;
			last_s4 <= last_s3;
		end
	end

	// split word into parts per wire format
	logic [15:0] re_part, im_part;

	always_comb begin
		case (cfg.wire_format)
			FMT_ITEM32_LE: begin
				re_part = raw_s1[31:16];
				im_part = raw_s1[15:0];
			end
			FMT_ITEM32_BE: begin
				re_part = {raw_s1[7:0], raw_s1[15:8]};
				im_part = {raw_s1[23:16], raw_s1[31:24]};
			end
			default: begin
				re_part = raw_s1[15:0];
				im_part = raw_s1[31:16];
			end
		endcase
	end

	ci2f_part u_re (
		.clk    (clk),
		.adv    (adv),
		.part   (re_part),
		.scale  (cfg.scale_bits),
		.result (dout.real_out)
	);

	ci2f_part u_im (
		.clk    (clk),
		.adv    (adv),
		.part   (im_part),
		.scale  (cfg.scale_bits),
		.result (dout.imag_out)
	);

	assign dout.valid    = vld_s4;
	assign dout.last_out = last_s4;
endmodule

/* tb/tb_complex_int16_to_float32_scaler_core.sv */
// ----------------------------------------------------------------------------
// tb_complex_int16_to_float32_scaler_core
// Self-checking bench for the complex int16 to float32 scaler: directed table of
// corner samples, special scales in each format, then random words under several
// formats and scales, with random idling on both channels and a scoreboard of predicted float pairs.
// ----------------------------------------------------------------------------
module tb_complex_int16_to_float32_scaler_core;
	timeunit 1ns;
	timeprecision 1ps;
	import ci2f_pkg::*;

	typedef struct {
		logic [31:0] re;
		logic [31:0] im;
		logic        last;
	} fpair_t;

	typedef struct {
		logic [31:0] word;
		logic        last;
		logic        known;
		logic [31:0] re;
		logic [31:0] im;
	} vec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	ci2f_in_if din ();
	ci2f_out_if dout ();

	complex_int16_to_float32_scaler_core u_top (
		.clk(clk), .arst_n(arst_n), .din(din), .dout(dout),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// mirror of the block's registers
	logic [1:0]  fmt_q = FMT_ITEM32_LE;
	logic [31:0] scale_q = ONE_F32;

	fpair_t expected_pairs[$];
	int errors = 0;
	int src_idle = 33;
	int snk_idle = 84;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#50ms;
		$display("complex_int16_to_float32_scaler_core regression: fail");
		$finish;
	end

	// one 16-bit part times a float32 scale, rounded to nearest even
	function automatic logic [31:0] scale_int16(logic [15:0] h, logic [31:0] sc);
		logic        neg;
		logic [16:0] mag;
		logic [31:0] sgn;
		logic [7:0]  ex;
		logic [22:0] fr;
		int          eeff, top, be, sh;
		logic [63:0] prod, mant, rem, half;
		neg = h[15];
		mag = neg ? (17'h10000 - {1'b0, h}) : {1'b0, h};
		sgn = {sc[31] ^ neg, 31'b0};
		ex = sc[30:23];
		fr = sc[22:0];
		if (ex == 8'hFF) begin
			if (fr != 0) return sc | QUIET_BIT;
			if (mag == 0) return DEFAULT_NAN;
			return sgn | {1'b0, INF_MAG};
		end
		if (mag == 0) return {sc[31], 31'b0};
		if (ex == 0 && fr == 0) return sgn;
		eeff = (ex != 0) ? ex : 1;
		prod = 64'(mag) * 64'((ex != 0) ? {1'b1, fr} : {1'b0, fr});
		top = 0;
		while (top < 63 && (prod >> (top + 1)) != 0) top++;
		be = top + eeff - 23;
		if (be < 1) begin
			mant = prod << (eeff - 1);
			return sgn | {9'b0, mant[22:0]};
		end
		if (top <= 23) begin
			mant = prod << (23 - top);
		end else begin
			sh = top - 23;
			rem = prod & ((64'd1 << sh) - 1);
			half = 64'd1 << (sh - 1);
			mant = prod >> sh;
			if (rem > half || (rem == half && mant[0])) mant++;
			if (mant >> 24) begin
				mant = mant >> 1;
				be++;
			end
		end
		if (be >= 255) return sgn | {1'b0, INF_MAG};
		return sgn | {1'b0, be[7:0], mant[22:0]};
	endfunction

	function automatic fpair_t convert_sample(logic [31:0] w, logic last);
		fpair_t p;
		logic [15:0] re, im;
		case (fmt_q)
			FMT_ITEM32_LE: begin
				re = w[31:16];
				im = w[15:0];
			end
			FMT_ITEM32_BE: begin
				re = {w[7:0], w[15:8]};
				im = {w[23:16], w[31:24]};
			end
			default: begin
				re = w[15:0];
				im = w[31:16];
			end
		endcase
		p.re = scale_int16(re, scale_q);
		p.im = scale_int16(im, scale_q);
		p.last = last;
		return p;
	endfunction

	// register write, setup then access
	task automatic apb_write(logic idx, logic [31:0] val);
		din.valid <= 1'b0;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_WIRE_FORMAT) fmt_q = val[1:0];
		else scale_q = val;
	endtask

	// send one sample word and queue its prediction
	task automatic send_sample(logic [31:0] w, logic last);
		if ($urandom_range(99) < src_idle) begin
			din.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < src_idle) @(posedge clk);
		end
		din.valid <= 1'b1;
		din.raw_word <= w;
		din.last_in <= last;
		expected_pairs.push_back(convert_sample(w, last));
		do @(posedge clk); while (!din.ready);
	endtask

	task automatic drain();
		int guard;
		din.valid <= 1'b0;
		guard = 0;
		while (expected_pairs.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
	endtask

	// output side: random stall, compare each transfer with oldest prediction
	always @(posedge clk) begin
		fpair_t e;
		dout.ready <= ($urandom_range(99) >= snk_idle);
		if (arst_n && dout.valid && dout.ready) begin
			if (expected_pairs.size() == 0) begin
				$display("%0t: unexpected transfer re=%h im=%h", $time,
					dout.real_out, dout.imag_out);
				errors++;
			end else begin
				e = expected_pairs.pop_front();
				if (dout.real_out !== e.re || dout.imag_out !== e.im ||
				    dout.last_out !== e.last) begin
					$display("%0t: mismatch expected %h %h %b actual %h %h %b", $time,
						e.re, e.im, e.last, dout.real_out, dout.imag_out,
						dout.last_out);
					errors++;
				end
			end
		end
	end

	initial begin
		vec_t dir[$];
		vec_t v;
		fpair_t p;
		logic [31:0] scales[$];
		int phase;
		din.valid = 1'b0;
		din.raw_word = '0;
		din.last_in = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows at reset settings (scale 1.0, little-endian)
		dir.push_back('{32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 32'h0000_0000});
		dir.push_back('{32'h7FFF_8000, 1'b1, 1'b1, 32'h46FF_FE00, 32'hC700_0000});
		dir.push_back('{32'h8000_7FFF, 1'b0, 1'b1, 32'hC700_0000, 32'h46FF_FE00});
		dir.push_back('{32'h0001_FFFF, 1'b1, 1'b1, 32'h3F80_0000, 32'hBF80_0000});
		dir.push_back('{32'hFFFF_FFFF, 1'b0, 1'b1, 32'hBF80_0000, 32'hBF80_0000});
		dir.push_back('{32'h1234_ABCD, 1'b1, 1'b0, 0, 0});
		foreach (dir[i]) begin
			v = dir[i];
			if (v.known) begin
				p = convert_sample(v.word, v.last);
				if (p.re !== v.re || p.im !== v.im) begin
					$display("%0t: mismatch expected %h %h actual %h %h", $time,
						v.re, v.im, p.re, p.im);
					errors++;
				end
			end
			send_sample(v.word, v.last);
		end
		drain();

		// each format and special scales: zero, -zero, inf, -inf, nan, subnormal, huge
		scales = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
			32'h7F80_0001, 32'hFFA5_5555, 32'h0000_0001, 32'h007F_FFFF,
			32'h7F7F_FFFF, 32'h3800_0001, 32'hFFFF_FFFF, 32'h3F80_0000};
		for (int f = 0; f < 4; f++) begin
			apb_write(REG_WIRE_FORMAT, 32'(f));
			foreach (scales[s]) begin
				apb_write(REG_SCALE_BITS, scales[s]);
				send_sample(32'h8000_0000, 1'b0);
				send_sample(32'h0001_7FFF, 1'b1);
				send_sample(32'h0080_8001, 1'b0);
				drain();
			end
		end

		// random part in three idling phases
		for (phase = 0; phase < 3; phase++) begin
			src_idle = (phase == 0) ? 33 : (phase == 1) ? 84 : 0;
			snk_idle = (phase == 0) ? 84 : (phase == 1) ? 33 : 0;
			for (int blk = 0; blk < 6; blk++) begin
				apb_write(REG_WIRE_FORMAT, 32'($urandom_range(3)));
				case ($urandom_range(3))
					0: apb_write(REG_SCALE_BITS, $urandom());
					1: apb_write(REG_SCALE_BITS, {1'($urandom_range(1)),
						8'($urandom_range(100, 150)), 23'($urandom())});
					2: apb_write(REG_SCALE_BITS, {1'($urandom_range(1)),
						8'($urandom_range(0, 20)), 23'($urandom())});
					default: apb_write(REG_SCALE_BITS, {1'($urandom_range(1)),
						8'($urandom_range(235, 254)), 23'($urandom())});
				endcase
				for (int k = 0; k < 30; k++)
					send_sample($urandom(), 1'($urandom_range(1)));
				drain();
			end
		end

		if (errors == 0)
			$display("complex_int16_to_float32_scaler_core regression: pass");
		else
			$display("complex_int16_to_float32_scaler_core regression: fail");
		$finish;
	end
endmodule
